>>> rtl/smx_pkg.sv
// Shared types and constants for the stack machine executor.
// No dependencies; imported by the top, decode, execute and checker modules.
package smx_pkg;

  // Width of the reported stack depth field
  localparam int DEPTH_W = 9;
  // Width of one stack value (signed Q16.16 by default)
  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DUP   = 3'd3,
    CMD_SWAP  = 3'd4,
    CMD_DROP  = 3'd5,
    CMD_PRINT = 3'd6,
    CMD_HALT  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_HALT  = 2'd3
  } status_t;

  // Input item: one instruction
  typedef struct packed {
    cmd_t                      command;
    logic signed [VALUE_W-1:0] push_value;
  } in_item_t;

  // Result item: one per instruction
  typedef struct packed {
    logic signed [VALUE_W-1:0] print_value;
    logic                      printed;
    status_t                   status;
    logic [DEPTH_W-1:0]        depth_now;
  } out_item_t;

  // Decoded instruction handed from the decode stage to the execute stage
  typedef struct packed {
    cmd_t                      command;
    logic signed [VALUE_W-1:0] push_value;
    status_t                   status;
    logic                      wr;      // spill top of stack to memory
  } ctl_t;

endpackage

>>> rtl/stack_machine_executor.sv
// Top level of the stack machine executor.
// Depends on smx_pkg, smx_ram, smx_decode and smx_exec.
//
// Runs one stack instruction per item and returns one result item for each.
// Rate is one item per clock unless out_ready stalls the result; an item
// passes the decode stage register, which also takes the stack memory read,
// then the result register. The top of stack sits in a register and the
// entries below it in a simple dual-port RAM, so each item needs at most one
// read and one write; a read of an entry written at the same edge is
// forwarded. The stack memory needs no clearing after reset; only entries
// below the current depth ever affect a result. Underflow and overflow leave
// the stack unchanged and are reported in status. depth_now is 9 bits wide.
module stack_machine_executor #(
  parameter int STACK_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  smx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output smx_pkg::out_item_t out_data
);
  import smx_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic               accept;
  logic               done;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rdata;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               s1_valid;
  ctl_t               s1;
  logic [AW-1:0]      s1_waddr;
  logic [DW-1:0]      s1_depth;

  // take a new item whenever the execute stage is free or finishing
  assign in_ready = !s1_valid || done;
  assign accept   = in_valid && in_ready;

  smx_decode #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .done     (done),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_waddr (s1_waddr),
    .s1_depth (s1_depth)
  );

  smx_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  smx_exec #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_waddr  (s1_waddr),
    .s1_depth  (s1_depth),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rdata     (rdata),
    .out_ready (out_ready),
    .done      (done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/smx_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address collision. No dependencies.
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/smx_decode.sv
// Decode stage: tracks stack depth, checks under/overflow, issues the
// next-on-stack read and holds the instruction for the execute stage.
// Depends on smx_pkg.
module smx_decode #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  smx_pkg::in_item_t              item,
  input  logic                           done,
  output logic                           rd_en,
  output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  output logic                           s1_valid,
  output smx_pkg::ctl_t                  s1,
  output logic [$clog2(STACK_DEPTH)-1:0] s1_waddr,
  output logic [$clog2(STACK_DEPTH+1)-1:0] s1_depth
);
  import smx_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DMAX = DW'(STACK_DEPTH);

  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic [DW-1:0] dm1;
  logic [DW-1:0] dm2;
  ctl_t          ctl;
  logic [AW-1:0] waddr;

  assign dm1 = depth - DW'(1);
  assign dm2 = depth - DW'(2);

  // next-on-stack lives at depth-2; memory holds all entries below the top
  assign rd_en   = accept;
  assign rd_addr = dm2[AW-1:0];

  // checks and depth update, all from the depth before this item
  always_comb begin
    ctl.command    = item.command;
    ctl.push_value = item.push_value;
    ctl.status     = ST_OK;
    ctl.wr         = 1'b0;
    depth_next     = depth;
    waddr          = dm1[AW-1:0];
    case (item.command)
      CMD_PUSH: begin
        if (depth >= DMAX) begin
          ctl.status = ST_OVER;
        end else begin
          depth_next = depth + DW'(1);
          ctl.wr     = (depth != '0);
        end
      end
      CMD_ADD, CMD_MUL: begin
        if (depth < DW'(2)) begin
          ctl.status = ST_UNDER;
        end else begin
          depth_next = dm1;
        end
      end
      CMD_SWAP: begin
        if (depth < DW'(2)) begin
          ctl.status = ST_UNDER;
        end else begin
          ctl.wr = 1'b1;
          waddr  = dm2[AW-1:0];
        end
      end
      CMD_DUP: begin
        if (depth == '0) begin
          ctl.status = ST_UNDER;
        end else if (depth >= DMAX) begin
          ctl.status = ST_OVER;
        end else begin
          depth_next = depth + DW'(1);
          ctl.wr     = 1'b1;
        end
      end
      CMD_DROP, CMD_PRINT: begin
        if (depth == '0) begin
          ctl.status = ST_UNDER;
        end else begin
          depth_next = dm1;
        end
      end
      CMD_HALT: begin
        ctl.status = ST_HALT;
        depth_next = '0;
      end
      default: begin
        ctl.status = ST_HALT;
        depth_next = '0;
      end
    endcase
  end

  // depth and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      s1_valid <= 1'b0;
    end else if (accept) begin
      depth    <= depth_next;
      s1_valid <= 1'b1;
    end else if (done) begin
      s1_valid <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= ctl;
      s1_waddr <= waddr;
      s1_depth <= depth_next;
    end
  end

endmodule

>>> rtl/smx_exec.sv
// Execute stage: top-of-stack register, saturating add and multiply,
// spill writes, read forwarding and the result register.
// Depends on smx_pkg.
module smx_exec #(
  parameter int STACK_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s1_valid,
  input  smx_pkg::ctl_t                    s1,
  input  logic [$clog2(STACK_DEPTH)-1:0]   s1_waddr,
  input  logic [$clog2(STACK_DEPTH+1)-1:0] s1_depth,
  input  logic                             rd_en,
  input  logic [$clog2(STACK_DEPTH)-1:0]   rd_addr,
  input  logic [smx_pkg::VALUE_W-1:0]      rdata,
  input  logic                             out_ready,
  output logic                             done,
  output logic                             wr_en,
  output logic [$clog2(STACK_DEPTH)-1:0]   wr_addr,
  output logic [smx_pkg::VALUE_W-1:0]      wr_data,
  output logic                             out_valid,
  output smx_pkg::out_item_t               out_data
);
  import smx_pkg::*;

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic signed [VALUE_W-1:0]   tos;
  logic signed [VALUE_W-1:0]   tos_next;
  logic signed [VALUE_W-1:0]   nos;
  logic                        fwd;
  logic [VALUE_W-1:0]          fwd_data;
  logic signed [VALUE_W:0]     sum;
  logic signed [2*VALUE_W-1:0] prod;
  logic signed [2*VALUE_W-1:0] prod_sh;
  logic signed [VALUE_W-1:0]   add_res;
  logic signed [VALUE_W-1:0]   mul_res;
  out_item_t                   res;

  // stage completes when the result register is free or being emptied
  assign done = s1_valid && (!out_valid || out_ready);

  // spill the current top of stack
  assign wr_en   = done && s1.wr;
  assign wr_addr = s1_waddr;
  assign wr_data = tos;

  // RAM is read-first: catch a read of the entry written at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= tos;
    end
  end

  assign nos = fwd ? fwd_data : rdata;

  // saturating add
  always_comb begin
    sum = {nos[VALUE_W-1], nos} + {tos[VALUE_W-1], tos};
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      add_res = sum[VALUE_W] ? VMIN : VMAX;
    end else begin
      add_res = sum[VALUE_W-1:0];
    end
  end

  // multiply, drop fraction bits (floor), saturate
  always_comb begin
    prod    = nos * tos;
    prod_sh = prod >>> FRAC_BITS;
    if (prod_sh[2*VALUE_W-1:VALUE_W-1] != {(VALUE_W+1){prod_sh[VALUE_W-1]}}) begin
      mul_res = prod_sh[2*VALUE_W-1] ? VMIN : VMAX;
    end else begin
      mul_res = prod_sh[VALUE_W-1:0];
    end
  end

  // new top of stack and result
  always_comb begin
    tos_next = tos;
    case (s1.command)
      CMD_PUSH:                       tos_next = s1.push_value;
      CMD_ADD:                        tos_next = add_res;
      CMD_MUL:                        tos_next = mul_res;
      CMD_SWAP, CMD_DROP, CMD_PRINT:  tos_next = nos;
      CMD_DUP, CMD_HALT:              tos_next = tos;
      default:                        tos_next = tos;
    endcase
    res.printed     = (s1.command == CMD_PRINT) && (s1.status == ST_OK);
    res.print_value = res.printed ? tos : '0;
    res.status      = s1.status;
    res.depth_now   = DEPTH_W'(s1_depth);
  end

  always_ff @(posedge clk) begin
    if (done && (s1.status == ST_OK)) begin
      tos <= tos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= res;
    end
  end

endmodule

>>> rtl/smx_chk.sv
// Port-level checker for the stack machine executor, bound to the top.
// Depends on smx_pkg.
module smx_chk (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input smx_pkg::out_item_t out_data
);
  import smx_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only a successful print emits a value
  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.printed |-> out_data.status == ST_OK)
    else $error("print flagged with bad status");

  // no value without a print
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.printed |-> out_data.print_value == '0)
    else $error("nonzero value without print");

  // halt always leaves an empty stack
  a_halt_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_HALT |-> out_data.depth_now == '0)
    else $error("halt left entries on the stack");

endmodule

bind stack_machine_executor smx_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
